// File: hdl/snp_pkg.sv
// Shared types and constants for the slope map to normal pixel pipeline.
package snp_pkg;

  localparam int SlopeW = 23;
  localparam int SqW = 46;
  localparam int LenW = 48;
  localparam int RemW = 79;
  localparam int DimW = 96;
  localparam int SumW = DimW + 1;
  localparam int RootW = 25;
  localparam int ProdW = SlopeW + RootW;
  localparam int NumCells = RootW;

  localparam logic [15:0] GainReset = 16'd5120;
  localparam logic [7:0] AlphaByte = 8'hFF;
  localparam logic [RemW-1:0] RemInit = {1'b1, {(RemW-1){1'b0}}};
  localparam logic [LenW-1:0] UnitLenSq = LenW'(64'd1 << 30);

  typedef struct packed {
    logic              xneg;
    logic              yneg;
    logic [SlopeW-1:0] xm;
    logic [SlopeW-1:0] ym;
  } snp_pix_t;

  typedef struct packed {
    logic             vld;
    snp_pix_t         pix;
    logic [RemW-1:0]  rem;
    logic [RemW-1:0]  w;
    logic [DimW-1:0]  d;
    logic [RootW-1:0] r;
  } snp_cell_t;

endpackage

// File: hdl/snp_front.sv
// Front stages: slope magnitudes, gain products, squares and root seed.
module snp_front import snp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_vld,
  input  logic [7:0]  slope_red,
  input  logic [7:0]  slope_green,
  input  logic [15:0] bump_gain,
  output snp_cell_t   cell_out
);

  logic [7:0] green_inv;
  logic [7:0] xd;
  logic [7:0] yd;
  logic [23:0] xprod;
  logic [23:0] yprod;
  snp_pix_t pix_next;

  logic v1;
  snp_pix_t p1;
  logic v2;
  snp_pix_t p2;
  logic [SqW-1:0] xsq;
  logic [SqW-1:0] ysq;
  logic [LenW-1:0] len_sq;

  always_comb begin
    green_inv = 8'd255 - slope_green;
    pix_next.xneg = !slope_red[7];
    pix_next.yneg = !green_inv[7];
    xd = pix_next.xneg ? 8'd128 - slope_red : slope_red - 8'd128;
    yd = pix_next.yneg ? 8'd128 - green_inv : green_inv - 8'd128;
    xprod = {16'd0, xd} * {8'd0, bump_gain};
    yprod = {16'd0, yd} * {8'd0, bump_gain};
    pix_next.xm = xprod[SlopeW-1:0];
    pix_next.ym = yprod[SlopeW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v1 <= in_vld;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1 <= pix_next;
      p2 <= p1;
      xsq <= {{SlopeW{1'b0}}, p1.xm} * {{SlopeW{1'b0}}, p1.xm};
      ysq <= {{SlopeW{1'b0}}, p1.ym} * {{SlopeW{1'b0}}, p1.ym};
    end
  end

  always_comb begin
    len_sq = {2'b00, xsq} + {2'b00, ysq} + UnitLenSq;
    cell_out.vld = v2;
    cell_out.pix = p2;
    cell_out.rem = RemInit;
    cell_out.w = '0;
    cell_out.d = {len_sq, {(DimW-LenW){1'b0}}};
    cell_out.r = '0;
  end

endmodule

// File: hdl/snp_cell.sv
// One digit cell of the reciprocal square root chain.
module snp_cell import snp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  snp_cell_t cell_in,
  output snp_cell_t cell_out
);

  logic [SumW-1:0] trial;
  logic acc;
  snp_cell_t cell_next;

  // The remainder tracks 2^78 minus r^2 * S; w and d carry the cross and
  // square terms of the next trial bit, prescaled so every cell is identical.
  always_comb begin
    trial = {{(SumW-RemW){1'b0}}, cell_in.w} + {1'b0, cell_in.d};
    acc = trial <= {{(SumW-RemW){1'b0}}, cell_in.rem};
    cell_next.vld = cell_in.vld;
    cell_next.pix = cell_in.pix;
    cell_next.rem = acc ? cell_in.rem - trial[RemW-1:0] : cell_in.rem;
    cell_next.w = (cell_in.w >> 1) + (acc ? cell_in.d[RemW-1:0] : {RemW{1'b0}});
    cell_next.d = cell_in.d >> 2;
    cell_next.r = {cell_in.r[RootW-2:0], acc};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_out <= '0;
    end else if (en) begin
      cell_out <= cell_next;
    end
  end

endmodule

// File: hdl/snp_map.sv
// Output stages: scale slopes by the reciprocal root and map to bytes.
module snp_map import snp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  snp_cell_t cell_in,
  output logic      out_vld,
  output logic [7:0] normal_x,
  output logic [7:0] normal_y,
  output logic [7:0] normal_z
);

  localparam logic [ProdW-1:0] Half = ProdW'(64'd1 << 39);

  function automatic logic [7:0] to_byte(input logic [ProdW-1:0] mag, input logic neg);
    logic [ProdW-1:0] m;
    logic [40:0] u;
    logic [48:0] t;
    m = (mag > Half) ? Half : mag;
    u = neg ? 41'(Half - m) : 41'(Half + m);
    t = {u, 8'd0} - {8'd0, u};
    return t[47:40];
  endfunction

  logic m1_vld;
  logic m1_xneg;
  logic m1_yneg;
  logic [ProdW-1:0] px;
  logic [ProdW-1:0] py;
  logic [ProdW-1:0] pz;

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_vld <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      m1_vld <= cell_in.vld;
      out_vld <= m1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_xneg <= cell_in.pix.xneg && (cell_in.pix.xm != '0);
      m1_yneg <= cell_in.pix.yneg && (cell_in.pix.ym != '0);
      px <= {{RootW{1'b0}}, cell_in.pix.xm} * {{SlopeW{1'b0}}, cell_in.r};
      py <= {{RootW{1'b0}}, cell_in.pix.ym} * {{SlopeW{1'b0}}, cell_in.r};
      pz <= {{(ProdW-RootW-15){1'b0}}, cell_in.r, 15'd0};
      normal_x <= to_byte(px, m1_xneg);
      normal_y <= to_byte(py, m1_yneg);
      normal_z <= to_byte(pz, 1'b0);
    end
  end

endmodule

// File: hdl/slope_map_to_normal_pixel.sv
// Top level: slope map pixel to unit normal pixel, one request per clock.
// An accepted input request reaches m_tvalid through 30 register stages: two front stages,
// 25 reciprocal square root cells (one result bit each), two mapping stages and the output
// register. Throughput is one pixel per clock while m_tready stays high; a one-entry skid
// buffer behind the output register lets s_tready follow a register.
// Synchronous reset empties the pipeline and sets bump_gain to 20.0 (5120 in Q8.8).
module slope_map_to_normal_pixel import snp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic [15:0] cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // slope_red [7:0], slope_green [15:8]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // normal_x, normal_y, normal_z, alpha_out from bit 0
);

  logic [15:0] bump_gain;
  logic en;
  snp_cell_t link [NumCells+1];
  logic map_vld;
  logic [7:0] nx;
  logic [7:0] ny;
  logic [7:0] nz;
  logic out_valid;
  logic [23:0] out_data;
  logic skid_valid;
  logic [23:0] skid_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      bump_gain <= GainReset;
    end else if (cfg_wen) begin
      bump_gain <= cfg_wdata;
    end
  end

  assign en = !skid_valid;
  assign s_tready = en;

  snp_front u_front (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .in_vld      (s_tvalid),
    .slope_red   (s_tdata[7:0]),
    .slope_green (s_tdata[15:8]),
    .bump_gain   (bump_gain),
    .cell_out    (link[0])
  );

  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    snp_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .cell_in  (link[i]),
      .cell_out (link[i+1])
    );
  end

  snp_map u_map (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .cell_in  (link[NumCells]),
    .out_vld  (map_vld),
    .normal_x (nx),
    .normal_y (ny),
    .normal_z (nz)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (m_tready) begin
        out_data <= skid_data;
        skid_valid <= 1'b0;
      end
    end else if (map_vld) begin
      if (!out_valid || m_tready) begin
        out_valid <= 1'b1;
        out_data <= {nz, ny, nx};
      end else begin
        skid_valid <= 1'b1;
        skid_data <= {nz, ny, nx};
      end
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata = {AlphaByte, out_data};

  a_skid_implies_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid buffer holds a request while the output register is empty");

  a_skid_holds: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && !m_tready) |=> skid_valid)
    else $error("skid buffer dropped a request that was not taken");

  a_overflow_to_skid: assert property (@(posedge clk) disable iff (rst)
    (!skid_valid && map_vld && out_valid && !m_tready) |=> skid_valid)
    else $error("stalled result was not captured by the skid buffer");

  a_z_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[23:16] >= 8'd127))
    else $error("normal z byte below the half-space range");

endmodule
